// ----- rtl/dfr_pkg.sv -----
// Package for the serial frame deframer: frame constants, codes and the
// structs passed between the front end, the back end and the queues.
// No dependencies.
`timescale 1ns / 1ps

package dfr_pkg;

   // Default sizes for the top-level parameters.
   localparam int BUFFER_BYTES_DEF = 32;
   localparam int CHANNELS_OUT_DEF = 10;

   // Depths of the two small queues.
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   // Width of frame lengths and of byte offsets within a frame.
   localparam int LEN_W = 6;

   // Frame header bytes and lengths.
   localparam logic [7:0]       LEGACY_HEADER = 8'h55;
   localparam logic [LEN_W-1:0] LEGACY_LENGTH = 6'd31;
   localparam int               LEGACY_WORDS  = 14;
   localparam logic [LEN_W-1:0] LONG_LENGTH   = 6'd32;
   localparam logic [LEN_W-1:0] SHORT_LENGTH  = 6'd4;

   // Legacy frame: words at odd offsets up to this byte are summed.
   localparam logic [LEN_W-1:0] LEGACY_SUM_END = LEN_W'(2 * LEGACY_WORDS);

   // Long frame checksum target and the first channel byte.
   localparam logic [16:0]      SUM_TARGET = 17'h0FFFF;
   localparam logic [LEN_W-1:0] CHAN_FIRST = 6'd2;

   // Input item codes.
   localparam logic FUNC_BYTE      = 1'b0;
   localparam logic FUNC_FRAME_END = 1'b1;

   typedef enum logic {
      MODEL_LONG,
      MODEL_LEGACY
   } frame_model_type;

   typedef enum logic [1:0] {
      KIND_LONG   = 2'd0,
      KIND_SHORT  = 2'd1,
      KIND_LEGACY = 2'd2
   } frame_kind_type;

   // Frame end command, as classified by the front end.
   typedef struct packed {
      frame_model_type  model;
      logic [LEN_W-1:0] len;
      logic             reader_busy;
      frame_kind_type   kind;
   } cmd_type;

   // One result item.
   typedef struct packed {
      logic           frame_ok;
      frame_kind_type frame_kind;
      logic           channel_valid;
      logic [3:0]     channel_index;
      logic [15:0]    channel_value;
      logic           last;
   } rsp_type;

endpackage

// ----- rtl/rc_serial_frame_deframer_core.sv -----
// Top level of the serial frame deframer: front end, command queue, frame
// buffer RAM, back end and result queue.
// Depends on dfr_pkg, dfr_fifo, dfr_ram, dfr_front and dfr_back.
`timescale 1ns / 1ps

// Deframer for a hobby radio-control serial link. Each input item is either a
// received byte or a frame end event. A byte is accepted once the back end is
// idle and no frame end is waiting; a frame end is accepted whenever the
// command queue has room. For each frame end the back end reads the frame
// buffer a byte at a time through its single registered RAM port: first the
// checksum sweep over the frame, then two byte reads and one queue push for
// each emitted channel of a good long frame. A busy reader or a frame end
// before any frame skips the sweep and goes straight to the report. Results
// wait in a small queue, so the back end keeps working while the consumer
// holds off, until that queue is full.

module rc_serial_frame_deframer_core #(
   parameter int BUFFER_BYTES = dfr_pkg::BUFFER_BYTES_DEF,
   parameter int CHANNELS_OUT = dfr_pkg::CHANNELS_OUT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   input  logic        req_reader_busy,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_frame_ok,
   output logic [1:0]  rsp_frame_kind,
   output logic        rsp_channel_valid,
   output logic [3:0]  rsp_channel_index,
   output logic [15:0] rsp_channel_value,
   output logic        rsp_last
);

   localparam int AW = $clog2(BUFFER_BYTES);

   logic                    back_idle;
   logic                    cmdq_push, cmdq_pop, cmdq_full, cmdq_empty;
   dfr_pkg::cmd_type        cmdq_in, cmdq_out;
   logic                    buf_wr_en, buf_rd_en;
   logic [AW-1:0]           buf_wr_addr, buf_rd_addr;
   logic [7:0]              buf_wr_data, buf_rd_data;
   logic [BUFFER_BYTES-1:0] buf_valid;
   logic                    rspq_push, rspq_full;
   dfr_pkg::rsp_type        rspq_in, rspq_out;

   // Front end: accepts and classifies input transfers.
   dfr_front #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_data_byte  (req_data_byte),
      .req_reader_busy(req_reader_busy),
      .back_idle      (back_idle),
      .cmdq_full      (cmdq_full),
      .cmdq_empty     (cmdq_empty),
      .cmdq_push      (cmdq_push),
      .cmdq_data      (cmdq_in),
      .buf_wr_en      (buf_wr_en),
      .buf_wr_addr    (buf_wr_addr),
      .buf_wr_data    (buf_wr_data),
      .buf_valid      (buf_valid)
   );

   // Frame end commands between the two halves.
   dfr_fifo #(
      .item_type(dfr_pkg::cmd_type),
      .DEPTH    (dfr_pkg::CMD_QUEUE_DEPTH)
   ) u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmdq_push),
      .push_data(cmdq_in),
      .full     (cmdq_full),
      .pop      (cmdq_pop),
      .pop_data (cmdq_out),
      .empty    (cmdq_empty)
   );

   // Frame buffer.
   dfr_ram #(
      .WIDTH(8),
      .DEPTH(BUFFER_BYTES)
   ) u_frame_ram (
      .clock  (clock),
      .wr_en  (buf_wr_en),
      .wr_addr(buf_wr_addr),
      .wr_data(buf_wr_data),
      .rd_en  (buf_rd_en),
      .rd_addr(buf_rd_addr),
      .rd_data(buf_rd_data)
   );

   // Back end: checksum and channel emission.
   dfr_back #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .CHANNELS_OUT(CHANNELS_OUT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmdq_data  (cmdq_out),
      .cmdq_empty (cmdq_empty),
      .cmdq_pop   (cmdq_pop),
      .buf_rd_en  (buf_rd_en),
      .buf_rd_addr(buf_rd_addr),
      .buf_rd_data(buf_rd_data),
      .buf_valid  (buf_valid),
      .rspq_full  (rspq_full),
      .rspq_push  (rspq_push),
      .rspq_data  (rspq_in),
      .back_idle  (back_idle)
   );

   // Result queue towards the consumer.
   dfr_fifo #(
      .item_type(dfr_pkg::rsp_type),
      .DEPTH    (dfr_pkg::RSP_QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (rspq_push),
      .push_data(rspq_in),
      .full     (rspq_full),
      .pop      (rsp_pop),
      .pop_data (rspq_out),
      .empty    (rsp_empty)
   );

   assign rsp_frame_ok      = rspq_out.frame_ok;
   assign rsp_frame_kind    = rspq_out.frame_kind;
   assign rsp_channel_valid = rspq_out.channel_valid;
   assign rsp_channel_index = rspq_out.channel_index;
   assign rsp_channel_value = rspq_out.channel_value;
   assign rsp_last          = rspq_out.last;

endmodule

// ----- rtl/dfr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- rtl/dfr_fifo.sv -----
// Small register queue used for commands and results.
// Depends on nothing; the item type is a parameter.
`timescale 1ns / 1ps

module dfr_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH = 2,
   localparam int PW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);

   item_type        slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count update, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/dfr_front.sv -----
// Front end of the deframer: accepts input items, tracks the frame start,
// writes bytes into the frame buffer and queues frame end commands.
// Depends on dfr_pkg.
`timescale 1ns / 1ps

module dfr_front #(
   parameter int  BUFFER_BYTES = dfr_pkg::BUFFER_BYTES_DEF,
   localparam int AW = $clog2(BUFFER_BYTES),
   localparam int CW = $clog2(BUFFER_BYTES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic                    req_func,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_reader_busy,
   input  logic                    back_idle,
   input  logic                    cmdq_full,
   input  logic                    cmdq_empty,
   output logic                    cmdq_push,
   output dfr_pkg::cmd_type        cmdq_data,
   output logic                    buf_wr_en,
   output logic [AW-1:0]           buf_wr_addr,
   output logic [7:0]              buf_wr_data,
   output logic [BUFFER_BYTES-1:0] buf_valid
);

   logic [CW-1:0]                byte_count_ff, byte_count_in;
   dfr_pkg::frame_model_type     model_ff, model_in;
   logic [dfr_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [BUFFER_BYTES-1:0]      valid_ff, valid_in;
   logic                         accept;
   logic                         hdr_long, hdr_legacy;
   logic                         take_byte, store_byte;
   dfr_pkg::frame_kind_type      kind;

   // A byte may only touch the buffer once the back end has finished with it;
   // a frame end only needs room in the command queue.
   assign req_full = (req_func == dfr_pkg::FUNC_FRAME_END) ? cmdq_full
                                                           : (!cmdq_empty || !back_idle);
   assign accept   = req_push && !req_full;

   // Header classification of the first byte of a frame.
   assign hdr_long   = (req_data_byte == 8'(dfr_pkg::SHORT_LENGTH)) ||
                       (req_data_byte == 8'(dfr_pkg::LONG_LENGTH));
   assign hdr_legacy = (req_data_byte == dfr_pkg::LEGACY_HEADER);
   assign take_byte  = accept && (req_func == dfr_pkg::FUNC_BYTE) &&
                       ((byte_count_ff != '0) || hdr_long || hdr_legacy);
   assign store_byte = take_byte && (byte_count_ff < CW'(BUFFER_BYTES));

   // Frame kind reported at frame end.
   always_comb begin
      if (model_ff == dfr_pkg::MODEL_LEGACY) begin
         kind = dfr_pkg::KIND_LEGACY;
      end else if (len_ff == dfr_pkg::SHORT_LENGTH) begin
         kind = dfr_pkg::KIND_SHORT;
      end else begin
         kind = dfr_pkg::KIND_LONG;
      end
   end

   // Next state of the byte count, frame model, length and valid bits.
   always_comb begin
      byte_count_in = byte_count_ff;
      model_in      = model_ff;
      len_in        = len_ff;
      valid_in      = valid_ff;
      if (accept && (req_func == dfr_pkg::FUNC_FRAME_END)) begin
         byte_count_in = '0;
      end
      if (take_byte && (byte_count_ff == '0)) begin
         if (hdr_legacy) begin
            model_in = dfr_pkg::MODEL_LEGACY;
            len_in   = dfr_pkg::LEGACY_LENGTH;
         end else begin
            model_in = dfr_pkg::MODEL_LONG;
            len_in   = req_data_byte[dfr_pkg::LEN_W-1:0];
         end
      end
      if (store_byte) begin
         byte_count_in                       = byte_count_ff + 1'b1;
         valid_in[byte_count_ff[AW-1:0]]     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         model_ff      <= dfr_pkg::MODEL_LONG;
         len_ff        <= '0;
         valid_ff      <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         model_ff      <= model_in;
         len_ff        <= len_in;
         valid_ff      <= valid_in;
      end
   end

   // Frame end command carries a snapshot of the frame description.
   assign cmdq_push             = accept && (req_func == dfr_pkg::FUNC_FRAME_END);
   assign cmdq_data.model       = model_ff;
   assign cmdq_data.len         = len_ff;
   assign cmdq_data.reader_busy = req_reader_busy;
   assign cmdq_data.kind        = kind;

   // Buffer write port.
   assign buf_wr_en   = store_byte;
   assign buf_wr_addr = byte_count_ff[AW-1:0];
   assign buf_wr_data = req_data_byte;
   assign buf_valid   = valid_ff;

endmodule

// ----- rtl/dfr_back.sv -----
// Back end of the deframer: runs the checksum over the frame buffer and
// emits the report or the channel words for each frame end command.
// Depends on dfr_pkg.
`timescale 1ns / 1ps

module dfr_back #(
   parameter int  BUFFER_BYTES = dfr_pkg::BUFFER_BYTES_DEF,
   parameter int  CHANNELS_OUT = dfr_pkg::CHANNELS_OUT_DEF,
   localparam int AW = $clog2(BUFFER_BYTES)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dfr_pkg::cmd_type        cmdq_data,
   input  logic                    cmdq_empty,
   output logic                    cmdq_pop,
   output logic                    buf_rd_en,
   output logic [AW-1:0]           buf_rd_addr,
   input  logic [7:0]              buf_rd_data,
   input  logic [BUFFER_BYTES-1:0] buf_valid,
   input  logic                    rspq_full,
   output logic                    rspq_push,
   output dfr_pkg::rsp_type        rspq_data,
   output logic                    back_idle
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_CHECK,
      ST_REPORT,
      ST_CH_READ,
      ST_CH_DATA,
      ST_CH_PUSH
   } state_type;

   state_type                  state_ff;
   dfr_pkg::frame_model_type   model_ff;
   logic [dfr_pkg::LEN_W-1:0]  len_ff;
   dfr_pkg::frame_kind_type    kind_ff;
   logic [dfr_pkg::LEN_W-1:0]  addr_ff;
   logic                       vld_ff;
   logic [16:0]                sum_ff;
   logic [15:0]                tgt_ff;
   logic                       ok_ff;
   logic [3:0]                 idx_ff;
   logic [15:0]                word_ff;

   logic [7:0]                 rd_byte;
   logic [dfr_pkg::LEN_W-1:0]  len_m1;
   logic                       last_byte;
   logic                       check_ok;
   logic                       last_chan;
   logic [15:0]                legacy_add;

   // Unwritten buffer entries read as zero.
   assign rd_byte    = vld_ff ? buf_rd_data : 8'h00;
   assign len_m1     = len_ff - 1'b1;
   assign last_byte  = (model_ff == dfr_pkg::MODEL_LEGACY) ?
                       (addr_ff == dfr_pkg::LEGACY_LENGTH - 1'b1) : (addr_ff == len_m1);
   assign legacy_add = addr_ff[0] ? {8'h00, rd_byte} : {rd_byte, 8'h00};
   assign check_ok   = (model_ff == dfr_pkg::MODEL_LEGACY) ? (sum_ff[15:0] == tgt_ff)
                                                           : (sum_ff == dfr_pkg::SUM_TARGET);
   assign last_chan  = (idx_ff == 4'(CHANNELS_OUT - 1));

   assign back_idle   = (state_ff == ST_IDLE);
   assign cmdq_pop    = (state_ff == ST_IDLE) && !cmdq_empty;
   assign buf_rd_en   = (state_ff == ST_READ) || (state_ff == ST_CH_READ);
   assign buf_rd_addr = AW'(addr_ff);

   // Result item for the report and for each channel word.
   always_comb begin
      rspq_push = 1'b0;
      rspq_data = '0;
      rspq_data.frame_kind = kind_ff;
      if (state_ff == ST_REPORT) begin
         rspq_push          = !rspq_full;
         rspq_data.frame_ok = ok_ff;
         rspq_data.last     = 1'b1;
      end else if (state_ff == ST_CH_PUSH) begin
         rspq_push               = !rspq_full;
         rspq_data.frame_ok      = 1'b1;
         rspq_data.channel_valid = 1'b1;
         rspq_data.channel_index = idx_ff;
         rspq_data.channel_value = word_ff;
         rspq_data.last          = last_chan;
      end
   end

   // Sequencer: one buffer byte read and then summed per step of the checksum
   // sweep, then two bytes and a push for each channel word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (!cmdq_empty) begin
                  model_ff <= cmdq_data.model;
                  len_ff   <= cmdq_data.len;
                  kind_ff  <= cmdq_data.kind;
                  sum_ff   <= '0;
                  tgt_ff   <= '0;
                  if (cmdq_data.reader_busy) begin
                     ok_ff    <= 1'b0;
                     state_ff <= ST_REPORT;
                  end else if (cmdq_data.model == dfr_pkg::MODEL_LEGACY) begin
                     addr_ff  <= 6'd1;
                     state_ff <= ST_READ;
                  end else if (cmdq_data.len < 6'd2) begin
                     ok_ff    <= 1'b0;
                     state_ff <= ST_REPORT;
                  end else begin
                     addr_ff  <= '0;
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               vld_ff   <= buf_valid[buf_rd_addr];
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               if (model_ff == dfr_pkg::MODEL_LEGACY) begin
                  if (addr_ff <= dfr_pkg::LEGACY_SUM_END) begin
                     sum_ff <= {1'b0, sum_ff[15:0] + legacy_add};
                  end else if (addr_ff == dfr_pkg::LEGACY_SUM_END + 1'b1) begin
                     tgt_ff[7:0] <= rd_byte;
                  end else begin
                     tgt_ff[15:8] <= rd_byte;
                  end
               end else if (addr_ff == len_m1) begin
                  sum_ff <= sum_ff + {1'b0, rd_byte, 8'h00};
               end else begin
                  sum_ff <= sum_ff + {9'h000, rd_byte};
               end
               if (last_byte) begin
                  state_ff <= ST_CHECK;
               end else begin
                  addr_ff  <= addr_ff + 1'b1;
                  state_ff <= ST_READ;
               end
            end
            ST_CHECK: begin
               if (check_ok && (model_ff == dfr_pkg::MODEL_LONG) &&
                   (len_ff == dfr_pkg::LONG_LENGTH)) begin
                  addr_ff  <= dfr_pkg::CHAN_FIRST;
                  idx_ff   <= '0;
                  state_ff <= ST_CH_READ;
               end else begin
                  ok_ff    <= check_ok;
                  state_ff <= ST_REPORT;
               end
            end
            ST_REPORT: begin
               if (!rspq_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_CH_READ: begin
               vld_ff   <= buf_valid[buf_rd_addr];
               state_ff <= ST_CH_DATA;
            end
            ST_CH_DATA: begin
               if (!addr_ff[0]) begin
                  word_ff[7:0] <= rd_byte;
                  addr_ff      <= addr_ff + 1'b1;
                  state_ff     <= ST_CH_READ;
               end else begin
                  word_ff[15:8] <= rd_byte;
                  state_ff      <= ST_CH_PUSH;
               end
            end
            ST_CH_PUSH: begin
               if (!rspq_full) begin
                  if (last_chan) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     addr_ff  <= addr_ff + 1'b1;
                     state_ff <= ST_CH_READ;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- test/rc_serial_frame_deframer_checker.sv -----
// Checker for the serial frame deframer: watches both queue ports, predicts
// the results of every accepted input transfer and compares them in order.
// Depends on dfr_pkg.
`timescale 1ns / 1ps

module rc_serial_frame_deframer_checker #(
   parameter int BUFFER_BYTES = dfr_pkg::BUFFER_BYTES_DEF,
   parameter int CHANNELS_OUT = dfr_pkg::CHANNELS_OUT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   input  logic        req_reader_busy,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic        rsp_frame_ok,
   input  logic [1:0]  rsp_frame_kind,
   input  logic        rsp_channel_valid,
   input  logic [3:0]  rsp_channel_index,
   input  logic [15:0] rsp_channel_value,
   input  logic        rsp_last,
   output int          mismatch_count,
   output int          pending_count,
   output int          result_count,
   output int          channel_frame_count
);

   // Shadow copy of the deframer state.
   int unsigned                bytes_held;
   logic [7:0]                 frame_bytes [BUFFER_BYTES];
   dfr_pkg::frame_model_type   model_q;
   logic [dfr_pkg::LEN_W-1:0]  frame_len;

   // Results still owed by the block, oldest first.
   dfr_pkg::rsp_type owed_results [$];

   // Little-endian word from the buffer; positions past the end read as zero.
   function automatic logic [15:0] buffer_word(int unsigned pos);
      logic [15:0] word;
      word = 16'h0000;
      if (pos < BUFFER_BYTES) word[7:0] = frame_bytes[pos];
      if (pos + 1 < BUFFER_BYTES) word[15:8] = frame_bytes[pos + 1];
      return word;
   endfunction

   // Long model: plain byte sum plus the trailing word must hit the target.
   function automatic bit long_sum_ok();
      int unsigned total;
      total = 0;
      if (frame_len < 2) return 1'b0;
      for (int unsigned i = 0; i < frame_len - 2 && i < BUFFER_BYTES; i++)
         total += frame_bytes[i];
      return (total + buffer_word(frame_len - 2)) == dfr_pkg::SUM_TARGET;
   endfunction

   // Legacy model: fourteen words at odd offsets, summed modulo 2^16.
   function automatic bit legacy_sum_ok();
      logic [15:0] total;
      total = 16'h0000;
      for (int unsigned i = 0; i < dfr_pkg::LEGACY_WORDS; i++)
         total += buffer_word(1 + 2 * i);
      return total == buffer_word(dfr_pkg::LEGACY_LENGTH - 2);
   endfunction

   // Advances the shadow state by one input transfer and queues its results.
   function automatic void predict_frame_results(logic func, logic [7:0] data, logic busy);
      dfr_pkg::rsp_type       res;
      dfr_pkg::frame_kind_type kind;
      bit                     ok;
      if (func == dfr_pkg::FUNC_BYTE) begin
         // The first byte of a frame picks its model; anything else is dropped.
         if (bytes_held == 0) begin
            if (data == dfr_pkg::SHORT_LENGTH || data == dfr_pkg::LONG_LENGTH) begin
               model_q   = dfr_pkg::MODEL_LONG;
               frame_len = data[dfr_pkg::LEN_W-1:0];
            end else if (data == dfr_pkg::LEGACY_HEADER) begin
               model_q   = dfr_pkg::MODEL_LEGACY;
               frame_len = dfr_pkg::LEGACY_LENGTH;
            end else begin
               return;
            end
         end
         if (bytes_held < BUFFER_BYTES) begin
            frame_bytes[bytes_held] = data;
            bytes_held++;
         end
         return;
      end

      if (model_q == dfr_pkg::MODEL_LEGACY) kind = dfr_pkg::KIND_LEGACY;
      else if (frame_len == dfr_pkg::SHORT_LENGTH) kind = dfr_pkg::KIND_SHORT;
      else kind = dfr_pkg::KIND_LONG;

      ok = 1'b0;
      if (!busy) ok = (model_q == dfr_pkg::MODEL_LONG) ? long_sum_ok() : legacy_sum_ok();
      bytes_held = 0;

      // Only a good 32-byte long frame yields channel words.
      if (ok && model_q == dfr_pkg::MODEL_LONG && frame_len == dfr_pkg::LONG_LENGTH) begin
         for (int k = 0; k < CHANNELS_OUT; k++) begin
            res.frame_ok      = 1'b1;
            res.frame_kind    = kind;
            res.channel_valid = 1'b1;
            res.channel_index = k[3:0];
            res.channel_value = buffer_word(dfr_pkg::CHAN_FIRST + 2 * k);
            res.last          = (k == CHANNELS_OUT - 1);
            owed_results.push_back(res);
         end
      end else begin
         res.frame_ok      = ok;
         res.frame_kind    = kind;
         res.channel_valid = 1'b0;
         res.channel_index = 4'd0;
         res.channel_value = 16'h0000;
         res.last          = 1'b1;
         owed_results.push_back(res);
      end
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   // Both ports are sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      dfr_pkg::rsp_type want;
      if (reset) begin
         bytes_held = 0;
         for (int i = 0; i < BUFFER_BYTES; i++) frame_bytes[i] = 8'h00;
         model_q   = dfr_pkg::MODEL_LONG;
         frame_len = '0;
         owed_results.delete();
         mismatch_count      = 0;
         result_count        = 0;
         channel_frame_count = 0;
      end else begin
         if (req_push && !req_full)
            predict_frame_results(req_func, req_data_byte, req_reader_busy);
         if (rsp_pop && !rsp_empty) begin
            result_count++;
            if (owed_results.size() == 0) begin
               $error("result transfer with no result owed");
               mismatch_count++;
            end else begin
               want = owed_results.pop_front();
               check_field("frame_ok", want.frame_ok, rsp_frame_ok);
               check_field("frame_kind", want.frame_kind, rsp_frame_kind);
               check_field("channel_valid", want.channel_valid, rsp_channel_valid);
               check_field("channel_index", want.channel_index, rsp_channel_index);
               check_field("channel_value", want.channel_value, rsp_channel_value);
               check_field("last", want.last, rsp_last);
               if (want.last && want.channel_valid) channel_frame_count++;
            end
         end
      end
      pending_count = owed_results.size();
   end

endmodule

// ----- test/rc_serial_frame_deframer_core_tb.sv -----
// Top of the deframer testbench: clock, reset, frame stimulus and the
// consumer, with the checker beside the block and the final verdict.
// Depends on dfr_pkg, rc_serial_frame_deframer_core and the checker.
`timescale 1ns / 1ps

module rc_serial_frame_deframer_core_tb;

   localparam int BUFFER_BYTES = dfr_pkg::BUFFER_BYTES_DEF;
   localparam int CHANNELS_OUT = dfr_pkg::CHANNELS_OUT_DEF;

   typedef enum int {
      SHAPE_LONG,
      SHAPE_SHORT,
      SHAPE_LEGACY
   } frame_shape_type;

   typedef enum int {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES
   } fill_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_func = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_reader_busy = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_frame_ok;
   logic [1:0]  rsp_frame_kind;
   logic        rsp_channel_valid;
   logic [3:0]  rsp_channel_index;
   logic [15:0] rsp_channel_value;
   logic        rsp_last;

   int mismatch_count;
   int pending_count;
   int result_count;
   int channel_frame_count;

   // Stimulus bookkeeping.
   bit          no_idle = 1'b0;
   int unsigned items_sent = 0;
   int unsigned ends_sent = 0;
   logic [7:0]  frame_q [$];

   always #1 clock = ~clock;

   rc_serial_frame_deframer_core #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .CHANNELS_OUT (CHANNELS_OUT)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_func          (req_func),
      .req_data_byte     (req_data_byte),
      .req_reader_busy   (req_reader_busy),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_frame_ok      (rsp_frame_ok),
      .rsp_frame_kind    (rsp_frame_kind),
      .rsp_channel_valid (rsp_channel_valid),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last          (rsp_last)
   );

   rc_serial_frame_deframer_checker #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .CHANNELS_OUT (CHANNELS_OUT)
   ) u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_func            (req_func),
      .req_data_byte       (req_data_byte),
      .req_reader_busy     (req_reader_busy),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_frame_kind      (rsp_frame_kind),
      .rsp_channel_valid   (rsp_channel_valid),
      .rsp_channel_index   (rsp_channel_index),
      .rsp_channel_value   (rsp_channel_value),
      .rsp_last            (rsp_last),
      .mismatch_count      (mismatch_count),
      .pending_count       (pending_count),
      .result_count        (result_count),
      .channel_frame_count (channel_frame_count)
   );

   function automatic logic [7:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   function automatic logic [7:0] fill_byte(fill_mode_type fill);
      case (fill)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         default:   return rand_byte();
      endcase
   endfunction

   // Builds a well-formed frame with a correct checksum into frame_q.
   function automatic void build_frame(frame_shape_type shape, fill_mode_type fill);
      int unsigned length;
      logic [15:0] word;
      frame_q.delete();
      case (shape)
         SHAPE_LEGACY: begin
            frame_q.push_back(dfr_pkg::LEGACY_HEADER);
            for (int i = 1; i < dfr_pkg::LEGACY_SUM_END + 1; i++)
               frame_q.push_back(fill_byte(fill));
            word = 16'h0000;
            for (int i = 0; i < dfr_pkg::LEGACY_WORDS; i++)
               word += {frame_q[2 + 2 * i], frame_q[1 + 2 * i]};
         end
         default: begin
            length = (shape == SHAPE_SHORT) ? dfr_pkg::SHORT_LENGTH : dfr_pkg::LONG_LENGTH;
            frame_q.push_back(8'(length));
            for (int unsigned i = 1; i < length - 2; i++) frame_q.push_back(fill_byte(fill));
            word = 16'hFFFF;
            foreach (frame_q[i]) word -= 16'(frame_q[i]);
         end
      endcase
      frame_q.push_back(word[7:0]);
      frame_q.push_back(word[15:8]);
   endfunction

   // Spoils one byte somewhere in the frame, the header included.
   function automatic void corrupt_frame();
      int unsigned idx;
      idx = $urandom_range(0, frame_q.size() - 1);
      frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(1, 255));
   endfunction

   function automatic logic pick_busy();
      return ($urandom_range(0, 5) == 0);
   endfunction

   // One input transfer, after a random gap; inputs change at the falling edge.
   task automatic send_item(logic func, logic [7:0] data, logic busy);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func        = func;
      req_data_byte   = data;
      req_reader_busy = busy;
      req_push        = 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      items_sent++;
      if (func == dfr_pkg::FUNC_FRAME_END) ends_sent++;
   endtask

   task automatic send_byte(logic [7:0] data);
      send_item(dfr_pkg::FUNC_BYTE, data, 1'($urandom_range(0, 1)));
   endtask

   task automatic end_frame(logic busy);
      send_item(dfr_pkg::FUNC_FRAME_END, rand_byte(), busy);
   endtask

   task automatic send_frame_bytes(int unsigned count);
      for (int unsigned i = 0; i < count; i++) send_byte(frame_q[i]);
   endtask

   // Holds the sender off until every owed result has been transferred.
   task automatic wait_for_results();
      req_push = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Consumer: a random stall before each result, none while no_idle is set.
   initial begin
      int unsigned stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 16);
         if (stall != 0) begin
            rsp_pop = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop = 1'b1;
         do @(posedge clock); while (rsp_empty);
         @(negedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      int unsigned pick;
      int unsigned drain_cycles;
      frame_shape_type shape;
      fill_mode_type   fill;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Frame end straight after reset, then with the reader busy.
      end_frame(1'b0);
      end_frame(1'b1);

      // Stray bytes at both extremes are dropped before any frame starts.
      send_byte(8'h00);
      send_byte(8'hFF);
      end_frame(1'b0);

      // Good short telemetry frame, then one with a spoilt checksum.
      build_frame(SHAPE_SHORT, FILL_RANDOM);
      send_frame_bytes(frame_q.size());
      end_frame(1'b0);
      frame_q[2] = ~frame_q[2];
      send_frame_bytes(frame_q.size());
      end_frame(1'b0);

      // Long frame of all-ones channels, sent back to back.
      no_idle = 1'b1;
      build_frame(SHAPE_LONG, FILL_ONES);
      send_frame_bytes(frame_q.size());
      end_frame(1'b0);
      no_idle = 1'b0;

      // Frame end with no new bytes retests the old frame; busy skips the test.
      end_frame(1'b0);
      end_frame(1'b1);
      wait_for_results();

      // Random frames: mostly well formed, some spoilt, cut short or padded.
      while (items_sent < 160) begin
         no_idle = ($urandom_range(0, 3) == 0);
         pick    = $urandom_range(0, 99);
         case ($urandom_range(0, 9))
            0:       fill = FILL_ZERO;
            1:       fill = FILL_ONES;
            default: fill = FILL_RANDOM;
         endcase
         if (pick < 25) begin
            build_frame(SHAPE_LONG, fill);
            if ($urandom_range(0, 3) == 0) corrupt_frame();
            send_frame_bytes(frame_q.size());
            if ($urandom_range(0, 7) == 0)
               repeat ($urandom_range(1, 6)) send_byte(rand_byte());
            end_frame(pick_busy());
         end else if (pick < 45) begin
            build_frame(SHAPE_SHORT, fill);
            if ($urandom_range(0, 3) == 0) corrupt_frame();
            send_frame_bytes(frame_q.size());
            end_frame(pick_busy());
         end else if (pick < 65) begin
            build_frame(SHAPE_LEGACY, fill);
            if ($urandom_range(0, 3) == 0) corrupt_frame();
            send_frame_bytes(frame_q.size());
            if ($urandom_range(0, 5) == 0)
               repeat ($urandom_range(1, 6)) send_byte(rand_byte());
            end_frame(pick_busy());
         end else if (pick < 75) begin
            // Truncated frame: the check sees stale bytes from earlier frames.
            shape = frame_shape_type'($urandom_range(0, 2));
            build_frame(shape, fill);
            send_frame_bytes($urandom_range(1, frame_q.size() - 1));
            end_frame(pick_busy());
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) send_byte(rand_byte());
            end_frame(pick_busy());
         end else if (pick < 93) begin
            end_frame(pick_busy());
         end else begin
            wait_for_results();
         end
      end

      // Let the last results drain, then allow for the back end to settle.
      req_push     = 1'b0;
      drain_cycles = 0;
      while (pending_count != 0 && drain_cycles < 50000) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (200) @(negedge clock);
      if (pending_count != 0) $error("%0d owed results never arrived", pending_count);

      $display("Run covered %0d input transfers including %0d frame ends.",
               items_sent, ends_sent);
      $display("It checked %0d result transfers; %0d frames delivered channel words.",
               result_count, channel_frame_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog for a block that stops making progress.
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/dfr_pkg.sv
rtl/dfr_ram.sv
rtl/dfr_fifo.sv
rtl/dfr_front.sv
rtl/dfr_back.sv
rtl/rc_serial_frame_deframer_core.sv
test/rc_serial_frame_deframer_checker.sv
test/rc_serial_frame_deframer_core_tb.sv
